FILE: rtl/rmj_pkg.sv
// Shared types and constants for the radar measurement Jacobian unit.
package rmj_pkg;

    localparam int DATA_W = 32;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam int THR_W = 16;

    localparam logic [CFG_ADDR_W-1:0] ADDR_MIN_RANGE = 2'd0;
    localparam logic [THR_W-1:0] MIN_RANGE_RESET = 16'd7;

    typedef struct packed {
        logic signed [DATA_W-1:0] pos_x;
        logic signed [DATA_W-1:0] pos_y;
        logic signed [DATA_W-1:0] vel_x;
        logic signed [DATA_W-1:0] vel_y;
    } state_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] range_by_px;
        logic signed [DATA_W-1:0] range_by_py;
        logic signed [DATA_W-1:0] bearing_by_px;
        logic signed [DATA_W-1:0] bearing_by_py;
        logic signed [DATA_W-1:0] rate_by_px;
        logic signed [DATA_W-1:0] rate_by_py;
        logic                     near_zero_error;
    } jac_t;

endpackage

FILE: rtl/radar_measurement_jacobian_unit.sv
// Pipelined radar measurement Jacobian: square root, products and six dividers.
// Throughput: one word per cycle while jac_ready is high.
// The square root and each divider retire one bit per stage.
// A stall holds only stages nearer the output than any bubble, so bubbles get squeezed out.
// Reset clears every stage valid bit and sets min_range_squared to 7.
module radar_measurement_jacobian_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                state_valid,
    output logic                                state_ready,
    input  rmj_pkg::state_t                     state,
    output logic                                jac_valid,
    input  logic                                jac_ready,
    output rmj_pkg::jac_t                       jac,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rmj_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [rmj_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [rmj_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                pready
);

    localparam int W        = rmj_pkg::DATA_W;
    localparam int F        = FRAC_BITS;
    localparam int DW       = 3 * W;
    localparam int NW       = DW + F;
    localparam int NDIV     = 6;
    localparam int ST_MAG   = 0;
    localparam int ST_SQ    = 1;
    localparam int ST_SUM   = 2;
    localparam int ST_SQRT  = 3;
    localparam int ST_PART  = ST_SQRT + W;
    localparam int ST_ACC   = ST_PART + 1;
    localparam int ST_DPRE  = ST_ACC + 1;
    localparam int ST_DIV   = ST_DPRE + 1;
    localparam int ST_OUT   = ST_DIV + W;
    localparam int NST      = ST_OUT + 1;

    localparam logic signed [W-1:0] ONE_Q = W'(1) << F;

    typedef struct packed {
        logic                          px_neg;
        logic                          py_neg;
        logic                          px_nz;
        logic                          py_nz;
        logic [W-1:0]                  apx;
        logic [W-1:0]                  apy;
        logic signed [2*W-1:0]         prod_a;
        logic signed [2*W-1:0]         prod_b;
        logic [2*W-1:0]                sqx;
        logic [2*W-1:0]                sqy;
        logic [2*W-1:0]                dmag;
        logic                          dneg;
        logic [2*W-1:0]                s;
        logic                          near;
        logic [W:0]                    sq_rem;
        logic [W-1:0]                  sq_root;
        logic [2*W-1:0]                sr_lo;
        logic [2*W-1:0]                sr_hi;
        logic [2*W-1:0]                ny_lo;
        logic [2*W-1:0]                ny_hi;
        logic [2*W-1:0]                nx_lo;
        logic [2*W-1:0]                nx_hi;
        logic [DW-1:0]                 sr;
        logic [DW-1:0]                 ny;
        logic [DW-1:0]                 nx;
        logic [NDIV-1:0][W-1:0]        nlo;
        logic [NDIV-1:0][DW-1:0]       den;
        logic [NDIV-1:0][DW-1:0]       rem;
        logic [NDIV-1:0][W-1:0]        quo;
        logic [NDIV-1:0]               ovf;
        rmj_pkg::jac_t                 res;
    } pipe_t;

    function automatic logic [W-1:0] sat_q(input logic [W-1:0] q, input logic ovf,
                                           input logic neg);
        logic [W-1:0] lim;
        logic [W-1:0] v;
        lim = {1'b0, {(W-1){1'b1}}} + W'(neg);
        v = (ovf || q > lim) ? lim : q;
        return neg ? (~v + 1'b1) : v;
    endfunction

    logic [rmj_pkg::THR_W-1:0] min_range_squared_reg;
    logic [NST-1:0]            valid_reg;
    logic [NST:0]              ld;
    pipe_t                     stage_reg [NST];

    // APB register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_range_squared_reg <= rmj_pkg::MIN_RANGE_RESET;
        end
        else if (psel && penable && pwrite && paddr == rmj_pkg::ADDR_MIN_RANGE)
        begin
            min_range_squared_reg <= pwdata[rmj_pkg::THR_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == rmj_pkg::ADDR_MIN_RANGE) ?
                    rmj_pkg::CFG_DATA_W'(min_range_squared_reg) : '0;

    // a stage loads when it is empty or the stage ahead of it loads
    always_comb
    begin
        ld[NST] = jac_ready;
        for (int i = NST - 1; i >= 0; i--)
        begin
            ld[i] = !valid_reg[i] || ld[i+1];
        end
    end

    assign state_ready = ld[0];
    assign jac_valid   = valid_reg[NST-1];
    assign jac         = stage_reg[NST-1].res;

    for (genvar i = 0; i < NST; i++)
    begin : g_stage
        pipe_t stage_prev;
        pipe_t stage_next;

        if (i == 0)
        begin : g_src
            assign stage_prev = '0;
        end
        else
        begin : g_src
            assign stage_prev = stage_reg[i-1];
        end

        if (i == ST_MAG)
        begin : g_op
            always_comb
            begin
                stage_next        = stage_prev;
                stage_next.px_neg = state.pos_x[W-1];
                stage_next.py_neg = state.pos_y[W-1];
                stage_next.px_nz  = state.pos_x != '0;
                stage_next.py_nz  = state.pos_y != '0;
                stage_next.apx    = state.pos_x[W-1] ? (~state.pos_x + 1'b1) : state.pos_x;
                stage_next.apy    = state.pos_y[W-1] ? (~state.pos_y + 1'b1) : state.pos_y;
                stage_next.prod_a = (2*W)'(state.vel_x) * (2*W)'(state.pos_y);
                stage_next.prod_b = (2*W)'(state.vel_y) * (2*W)'(state.pos_x);
                stage_next.sq_rem  = '0;
                stage_next.sq_root = '0;
            end
        end
        else if (i == ST_SQ)
        begin : g_op
            always_comb
            begin
                stage_next      = stage_prev;
                stage_next.sqx  = (2*W)'(stage_prev.apx) * (2*W)'(stage_prev.apx);
                stage_next.sqy  = (2*W)'(stage_prev.apy) * (2*W)'(stage_prev.apy);
                stage_next.dneg = stage_prev.prod_b > stage_prev.prod_a;
                stage_next.dmag = stage_next.dneg ?
                                  $unsigned(stage_prev.prod_b - stage_prev.prod_a) :
                                  $unsigned(stage_prev.prod_a - stage_prev.prod_b);
            end
        end
        else if (i == ST_SUM)
        begin : g_op
            logic [2*W-1:0] sum;
            always_comb
            begin
                stage_next      = stage_prev;
                sum             = stage_prev.sqx + stage_prev.sqy;
                stage_next.s    = sum;
                stage_next.near = (sum == '0) ||
                                  (sum < ((2*W)'(min_range_squared_reg) << F));
            end
        end
        else if (i >= ST_SQRT && i < ST_PART)
        begin : g_op
            localparam int K = i - ST_SQRT;
            logic [W+1:0] sh;
            logic [W+1:0] trial;
            // one root bit per stage; root stays below 2^(W-1) until the last step
            always_comb
            begin
                stage_next = stage_prev;
                sh         = {stage_prev.sq_rem[W-1:0], stage_prev.s[2*W-1-2*K -: 2]};
                trial      = {stage_prev.sq_root, 2'b01};
                if (sh >= trial)
                begin
                    stage_next.sq_rem  = (W+1)'(sh - trial);
                    stage_next.sq_root = {stage_prev.sq_root[W-2:0], 1'b1};
                end
                else
                begin
                    stage_next.sq_rem  = sh[W:0];
                    stage_next.sq_root = {stage_prev.sq_root[W-2:0], 1'b0};
                end
            end
        end
        else if (i == ST_PART)
        begin : g_op
            always_comb
            begin
                stage_next       = stage_prev;
                stage_next.sr_lo = (2*W)'(stage_prev.s[W-1:0]) * (2*W)'(stage_prev.sq_root);
                stage_next.sr_hi = (2*W)'(stage_prev.s[2*W-1:W]) * (2*W)'(stage_prev.sq_root);
                stage_next.ny_lo = (2*W)'(stage_prev.apy) * (2*W)'(stage_prev.dmag[W-1:0]);
                stage_next.ny_hi = (2*W)'(stage_prev.apy) * (2*W)'(stage_prev.dmag[2*W-1:W]);
                stage_next.nx_lo = (2*W)'(stage_prev.apx) * (2*W)'(stage_prev.dmag[W-1:0]);
                stage_next.nx_hi = (2*W)'(stage_prev.apx) * (2*W)'(stage_prev.dmag[2*W-1:W]);
            end
        end
        else if (i == ST_ACC)
        begin : g_op
            always_comb
            begin
                stage_next    = stage_prev;
                stage_next.sr = DW'(stage_prev.sr_lo) + {stage_prev.sr_hi, W'(0)};
                stage_next.ny = DW'(stage_prev.ny_lo) + {stage_prev.ny_hi, W'(0)};
                stage_next.nx = DW'(stage_prev.nx_lo) + {stage_prev.nx_hi, W'(0)};
            end
        end
        else if (i == ST_DPRE)
        begin : g_op
            logic [NDIV-1:0][NW-1:0] num;
            logic [NDIV-1:0][DW-1:0] dsr;
            // quotient of W bits or saturate: overflow when the top of the numerator
            // already reaches the divisor
            always_comb
            begin
                stage_next = stage_prev;
                num[0] = NW'(stage_prev.apx) << F;
                num[1] = NW'(stage_prev.apy) << F;
                num[2] = NW'(stage_prev.apy) << (2 * F);
                num[3] = NW'(stage_prev.apx) << (2 * F);
                num[4] = NW'(stage_prev.ny) << F;
                num[5] = NW'(stage_prev.nx) << F;
                dsr[0] = DW'(stage_prev.sq_root);
                dsr[1] = DW'(stage_prev.sq_root);
                dsr[2] = DW'(stage_prev.s);
                dsr[3] = DW'(stage_prev.s);
                dsr[4] = stage_prev.sr;
                dsr[5] = stage_prev.sr;
                for (int j = 0; j < NDIV; j++)
                begin
                    stage_next.nlo[j] = num[j][W-1:0];
                    stage_next.den[j] = dsr[j];
                    stage_next.rem[j] = DW'(num[j][NW-1:W]);
                    stage_next.ovf[j] = DW'(num[j][NW-1:W]) >= dsr[j];
                    stage_next.quo[j] = '0;
                end
            end
        end
        else if (i >= ST_DIV && i < ST_OUT)
        begin : g_op
            localparam int K = i - ST_DIV;
            logic [NDIV-1:0][DW:0] sh;
            always_comb
            begin
                stage_next = stage_prev;
                for (int j = 0; j < NDIV; j++)
                begin
                    sh[j] = {stage_prev.rem[j], stage_prev.nlo[j][W-1-K]};
                    if (sh[j] >= {1'b0, stage_prev.den[j]})
                    begin
                        stage_next.rem[j] = DW'(sh[j] - {1'b0, stage_prev.den[j]});
                        stage_next.quo[j] = {stage_prev.quo[j][W-2:0], 1'b1};
                    end
                    else
                    begin
                        stage_next.rem[j] = sh[j][DW-1:0];
                        stage_next.quo[j] = {stage_prev.quo[j][W-2:0], 1'b0};
                    end
                end
            end
        end
        else
        begin : g_op
            logic [NDIV-1:0]        neg;
            logic [NDIV-1:0][W-1:0] val;
            always_comb
            begin
                stage_next = stage_prev;
                neg[0] = stage_prev.px_neg;
                neg[1] = stage_prev.py_neg;
                neg[2] = !stage_prev.py_neg && stage_prev.py_nz;
                neg[3] = stage_prev.px_neg;
                neg[4] = stage_prev.py_neg != stage_prev.dneg;
                neg[5] = (stage_prev.px_neg == stage_prev.dneg) &&
                         (stage_prev.dmag != '0) && stage_prev.px_nz;
                for (int j = 0; j < NDIV; j++)
                begin
                    val[j] = stage_prev.near ? '0 :
                             sat_q(stage_prev.quo[j], stage_prev.ovf[j], neg[j]);
                end
                stage_next.res.range_by_px     = val[0];
                stage_next.res.range_by_py     = val[1];
                stage_next.res.bearing_by_px   = val[2];
                stage_next.res.bearing_by_py   = val[3];
                stage_next.res.rate_by_px      = val[4];
                stage_next.res.rate_by_py      = val[5];
                stage_next.res.near_zero_error = stage_prev.near;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (ld[i])
            begin
                if (i == 0)
                begin
                    valid_reg[i] <= state_valid;
                end
                else
                begin
                    valid_reg[i] <= valid_reg[(i == 0) ? 0 : i-1];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (ld[i])
            begin
                stage_reg[i] <= stage_next;
            end
        end
    end

    a_ready_flows: assert property (@(posedge clk) disable iff (!rst_n)
        jac_ready |-> state_ready)
        else $error("input stalled while output is taken");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        state_valid && state_ready |=> valid_reg[0])
        else $error("accepted word missing from first stage");

    a_near_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        jac_valid && jac.near_zero_error |->
            jac.range_by_px == '0 && jac.range_by_py == '0 &&
            jac.bearing_by_px == '0 && jac.bearing_by_py == '0 &&
            jac.rate_by_px == '0 && jac.rate_by_py == '0)
        else $error("near zero word carries nonzero entries");

    a_range_unit: assert property (@(posedge clk) disable iff (!rst_n)
        jac_valid && !jac.near_zero_error |->
            jac.range_by_px <= ONE_Q && jac.range_by_px >= -ONE_Q)
        else $error("range_by_px exceeds unit magnitude");

endmodule
